@@ sv/fbpa_pkg.sv @@
`timescale 1ns / 1ps

package fbpa_pkg;

	localparam int ADDR_W         = 32;
	localparam int SIZE_W         = 16;
	localparam int BCNT_W         = 7;
	localparam int IDX_OUT_W      = 6;
	localparam int STAT_W         = 2;
	localparam int REQ_W          = 2;
	localparam int CFG_IDX_W      = 2;
	localparam int ROW_W          = 16;
	localparam int ROW_BIT_W      = 4;
	localparam int DEF_NUM_BLOCKS = 64;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RST = 16'd1;
	localparam logic [BCNT_W-1:0] BCNT_RST = 7'd64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_SCAN,
		ST_AWR,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FRD,
		ST_FWR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] quotient;
		logic [SIZE_W-1:0] remainder;
	} div_res_t;

	function automatic logic [ROW_BIT_W:0] row_popcount(input logic [ROW_W-1:0] v);
		return (ROW_BIT_W + 1)'($countones(v));
	endfunction

	// Index of the lowest set bit; only meaningful when v is non-zero.
	function automatic logic [ROW_BIT_W-1:0] row_first_set(input logic [ROW_W-1:0] v);
		logic [ROW_BIT_W-1:0] r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = ROW_BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ sv/fbpa_req_if.sv @@
`timescale 1ns / 1ps

interface fbpa_req_if;
	logic                                valid;
	logic                                ready;
	logic [fbpa_pkg::REQ_W-1:0]  req_type;
	logic [fbpa_pkg::ADDR_W-1:0] address;

	modport source (output valid, output req_type, output address, input ready);
	modport sink (input valid, input req_type, input address, output ready);
endinterface

@@ sv/fbpa_rsp_if.sv @@
`timescale 1ns / 1ps

interface fbpa_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic [fbpa_pkg::ADDR_W-1:0]    block_address;
	logic [fbpa_pkg::IDX_OUT_W-1:0] block_index;
	logic [fbpa_pkg::STAT_W-1:0]    status;
	logic [fbpa_pkg::BCNT_W-1:0]    free_count;
	logic                                   in_pool;

	modport source (output valid, output block_address, output block_index, output status,
		output free_count, output in_pool, input ready);
	modport sink (input valid, input block_address, input block_index, input status,
		input free_count, input in_pool, output ready);
endinterface

@@ sv/fbpa_ram.sv @@
`timescale 1ns / 1ps

module fbpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/fbpa_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module fbpa_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fbpa_pkg::div_req_t dreq,
	output fbpa_pkg::div_res_t dres
);

	localparam int AW = fbpa_pkg::ADDR_W;
	localparam int SW = fbpa_pkg::SIZE_W;
	localparam int NW = $clog2(AW);
	localparam logic [NW-1:0] LAST_STEP = NW'(AW - 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] step_q;
	logic [AW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [SW:0]   shifted;
	logic          take;

	assign shifted = {rem_q, quo_q[AW-1]};
	assign take    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + NW'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			quo_q <= dreq.dividend;
			rem_q <= '0;
			dvs_q <= dreq.divisor;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= SW'(shifted - {1'b0, dvs_q});
				quo_q <= {quo_q[AW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SW-1:0];
				quo_q <= {quo_q[AW-2:0], 1'b0};
			end
		end
	end

	assign dres.done      = done_q;
	assign dres.quotient  = quo_q;
	assign dres.remainder = rem_q;

endmodule

@@ sv/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps
// The used map holds ceil(NUM_BLOCKS / 16) rows (4 by default). Allocate and no-op scan all
// rows, then allocate marks the block found; free scans, divides, then rewrites the block's row;
// clear sweeps every row. One request at a time; the next is taken once the result
// sits in the output register. The row scan over the single read port and the bit-serial
// divider set the pace. Reset clears configuration to base 0, size 1, count 64, then sweeps
// the used-map memory, during which no request is taken.
module fixed_block_pool_allocator #(
	parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_wdata,
	fbpa_req_if.sink                            req,
	fbpa_rsp_if.source                          rsp
);

	localparam int AW   = fbpa_pkg::ADDR_W;
	localparam int SW   = fbpa_pkg::SIZE_W;
	localparam int BW   = fbpa_pkg::BCNT_W;
	localparam int OIW  = fbpa_pkg::IDX_OUT_W;
	localparam int RW   = fbpa_pkg::ROW_W;
	localparam int RBW  = fbpa_pkg::ROW_BIT_W;
	localparam int ROWS = (NUM_BLOCKS + RW - 1) / RW;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int XW   = RAW + RBW;
	localparam int CW   = $clog2(NUM_BLOCKS + 1);
	localparam int KW   = XW + 1;
	localparam int PW   = CW + SW;
	localparam int MW   = XW + SW;
	localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

	fbpa_pkg::state_t state_q, state_d;

	logic [AW-1:0] base_q;
	logic [SW-1:0] size_q;
	logic [BW-1:0] bcount_q;
	logic [CW-1:0] n_act;

	logic [fbpa_pkg::REQ_W-1:0] req_q;
	logic [AW-1:0]  addr_q;
	logic [CW-1:0]  cnt_q;
	logic [RAW-1:0] clr_row_q;
	logic           clr_resp_q;

	logic [RAW-1:0] scan_row_q;
	logic           scan_issued_q;
	logic           scan_vld_s1;
	logic [RAW-1:0] scan_row_s1;
	logic [RW-1:0]  row_mask;
	logic [RW-1:0]  row_free;
	logic           scan_last;

	logic           found_q;
	logic [RAW-1:0] found_row_q;
	logic [RBW-1:0] found_bit_q;
	logic [RW-1:0]  found_data_q;

	logic           match_q;
	logic           match_now;
	logic [XW-1:0]  free_idx_q;
	logic [XW-1:0]  free_idx_now;
	logic           addr_ge;

	logic [MW-1:0]  mul_q;
	logic [PW-1:0]  end_prod_q;

	logic           ram_we;
	logic [RAW-1:0] ram_waddr;
	logic [RW-1:0]  ram_wdata;
	logic           ram_re;
	logic [RAW-1:0] ram_raddr;
	logic [RW-1:0]  ram_rdata;

	fbpa_pkg::div_req_t div_req;
	fbpa_pkg::div_res_t div_res;

	logic           req_rdy;
	logic           rsp_load;
	logic           rsp_vld_q;
	logic [AW-1:0]  rsp_addr_q;
	logic [OIW-1:0] rsp_idx_q;
	logic [fbpa_pkg::STAT_W-1:0] rsp_stat_q;
	logic [BW-1:0]  rsp_free_q;
	logic           rsp_pool_q;

	logic [AW-1:0]     res_addr;
	logic [XW-1:0]     res_idx_full;
	logic [XW+OIW-1:0] res_idx_ext;
	logic [fbpa_pkg::STAT_W-1:0] res_stat;
	logic [CW+BW-1:0]  res_free_ext;
	logic              res_pool;
	logic              accept;

	fbpa_ram #(
		.WIDTH(RW),
		.DEPTH(ROWS)
	) u_used_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fbpa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.dreq  (div_req),
		.dres  (div_res)
	);

	assign accept = req.valid && req_rdy;

	always_comb begin
		if (32'(bcount_q) < 32'(NUM_BLOCKS)) begin
			n_act = CW'(bcount_q);
		end else begin
			n_act = CW'(NUM_BLOCKS);
		end
	end

	// Only blocks below the active count take part in the scan.
	always_comb begin
		for (int b = 0; b < RW; b++) begin
			row_mask[b] = KW'({scan_row_s1, RBW'(b)}) < KW'(n_act);
		end
	end

	assign row_free  = ~ram_rdata & row_mask;
	assign scan_last = scan_vld_s1 && (scan_row_s1 == LAST_ROW);

	// A zero block size puts every block at the base, so only block 0 can match.
	assign addr_ge = addr_q >= base_q;
	always_comb begin
		if (size_q == '0) begin
			match_now    = (addr_q == base_q) && (n_act != '0);
			free_idx_now = '0;
		end else begin
			match_now    = addr_ge && (div_res.remainder == '0) &&
				(div_res.quotient < AW'(n_act));
			free_idx_now = div_res.quotient[XW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.req_type == fbpa_pkg::REQ_CLEAR) begin
						state_d = fbpa_pkg::ST_CLR;
					end else begin
						state_d = fbpa_pkg::ST_SCAN;
					end
				end
			end
			fbpa_pkg::ST_CLR: begin
				if (clr_row_q == LAST_ROW) begin
					state_d = clr_resp_q ? fbpa_pkg::ST_RESP : fbpa_pkg::ST_IDLE;
				end
			end
			fbpa_pkg::ST_SCAN: begin
				if (scan_last) begin
					if (req_q == fbpa_pkg::REQ_ALLOC) begin
						if (found_q || (row_free != '0)) begin
							state_d = fbpa_pkg::ST_AWR;
						end else begin
							state_d = fbpa_pkg::ST_RESP;
						end
					end else if (req_q == fbpa_pkg::REQ_FREE) begin
						state_d = fbpa_pkg::ST_DIV_GO;
					end else begin
						state_d = fbpa_pkg::ST_RESP;
					end
				end
			end
			fbpa_pkg::ST_AWR:    state_d = fbpa_pkg::ST_RESP;
			fbpa_pkg::ST_DIV_GO: state_d = fbpa_pkg::ST_DIV_WAIT;
			fbpa_pkg::ST_DIV_WAIT: begin
				if (div_res.done) begin
					state_d = match_now ? fbpa_pkg::ST_FRD : fbpa_pkg::ST_RESP;
				end
			end
			fbpa_pkg::ST_FRD: state_d = fbpa_pkg::ST_FWR;
			fbpa_pkg::ST_FWR: state_d = fbpa_pkg::ST_RESP;
			fbpa_pkg::ST_RESP: begin
				if (!rsp_vld_q || rsp.ready) begin
					state_d = fbpa_pkg::ST_IDLE;
				end
			end
			default: state_d = fbpa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_rdy          = 1'b0;
		ram_we           = 1'b0;
		ram_waddr        = clr_row_q;
		ram_wdata        = '0;
		ram_re           = 1'b0;
		ram_raddr        = scan_row_q;
		div_req.start    = 1'b0;
		div_req.dividend = addr_q - base_q;
		div_req.divisor  = size_q;
		rsp_load         = 1'b0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: req_rdy = 1'b1;
			fbpa_pkg::ST_CLR:  ram_we = 1'b1;
			fbpa_pkg::ST_SCAN: ram_re = !scan_issued_q;
			fbpa_pkg::ST_AWR: begin
				ram_we    = 1'b1;
				ram_waddr = found_row_q;
				ram_wdata = found_data_q | (RW'(1) << found_bit_q);
			end
			fbpa_pkg::ST_DIV_GO:   div_req.start = 1'b1;
			fbpa_pkg::ST_DIV_WAIT: ;
			fbpa_pkg::ST_FRD: begin
				ram_re    = 1'b1;
				ram_raddr = free_idx_q[XW-1:RBW];
			end
			fbpa_pkg::ST_FWR: begin
				ram_we    = 1'b1;
				ram_waddr = free_idx_q[XW-1:RBW];
				ram_wdata = ram_rdata & ~(RW'(1) << free_idx_q[RBW-1:0]);
			end
			fbpa_pkg::ST_RESP: rsp_load = !rsp_vld_q || rsp.ready;
			default: ;
		endcase
	end

	always_comb begin
		res_addr     = '0;
		res_idx_full = '0;
		res_stat     = fbpa_pkg::STAT_OK;
		if (req_q == fbpa_pkg::REQ_ALLOC) begin
			if (found_q) begin
				res_addr     = base_q + AW'(mul_q);
				res_idx_full = {found_row_q, found_bit_q};
			end else begin
				res_stat = fbpa_pkg::STAT_FULL;
			end
		end else if (req_q == fbpa_pkg::REQ_FREE) begin
			if (match_q) begin
				res_idx_full = free_idx_q;
			end else begin
				res_stat = fbpa_pkg::STAT_NOT_FOUND;
			end
		end
		res_idx_ext  = {{OIW{1'b0}}, res_idx_full};
		res_free_ext = {{BW{1'b0}}, cnt_q};
		res_pool     = addr_ge && ({1'b0, addr_q} < ({1'b0, base_q} + (AW + 1)'(end_prod_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fbpa_pkg::ST_CLR;
			base_q        <= '0;
			size_q        <= fbpa_pkg::SIZE_RST;
			bcount_q      <= fbpa_pkg::BCNT_RST;
			cnt_q         <= '0;
			clr_row_q     <= '0;
			clr_resp_q    <= 1'b0;
			scan_row_q    <= '0;
			scan_issued_q <= 1'b0;
			scan_vld_s1   <= 1'b0;
			found_q       <= 1'b0;
			match_q       <= 1'b0;
			rsp_vld_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					fbpa_pkg::CFG_BASE:  base_q   <= cfg_wdata;
					fbpa_pkg::CFG_SIZE:  size_q   <= cfg_wdata[SW-1:0];
					fbpa_pkg::CFG_COUNT: bcount_q <= cfg_wdata[BW-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				clr_row_q     <= '0;
				clr_resp_q    <= req.req_type == fbpa_pkg::REQ_CLEAR;
				cnt_q         <= (req.req_type == fbpa_pkg::REQ_CLEAR) ? n_act : '0;
				scan_row_q    <= '0;
				scan_issued_q <= 1'b0;
				scan_vld_s1   <= 1'b0;
				found_q       <= 1'b0;
			end

			if (state_q == fbpa_pkg::ST_CLR && clr_row_q != LAST_ROW) begin
				clr_row_q <= clr_row_q + RAW'(1);
			end

			// Read rows one a cycle; each row is counted the cycle after its read.
			if (state_q == fbpa_pkg::ST_SCAN) begin
				if (!scan_issued_q) begin
					scan_vld_s1 <= 1'b1;
					if (scan_row_q == LAST_ROW) begin
						scan_issued_q <= 1'b1;
					end else begin
						scan_row_q <= scan_row_q + RAW'(1);
					end
				end else begin
					scan_vld_s1 <= 1'b0;
				end
				if (scan_vld_s1) begin
					cnt_q <= cnt_q + CW'(fbpa_pkg::row_popcount(row_free));
					if (!found_q && row_free != '0) begin
						found_q <= 1'b1;
					end
				end
			end

			if (state_q == fbpa_pkg::ST_AWR) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == fbpa_pkg::ST_DIV_WAIT && div_res.done) begin
				match_q <= match_now;
			end
			if (state_q == fbpa_pkg::ST_FWR && ram_rdata[free_idx_q[RBW-1:0]]) begin
				cnt_q <= cnt_q + CW'(1);
			end

			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req.req_type;
			addr_q <= req.address;
		end
		if (state_q == fbpa_pkg::ST_SCAN && !scan_issued_q) begin
			scan_row_s1 <= scan_row_q;
		end
		if (state_q == fbpa_pkg::ST_SCAN && scan_vld_s1 && !found_q && row_free != '0) begin
			found_row_q  <= scan_row_s1;
			found_bit_q  <= fbpa_pkg::row_first_set(row_free);
			found_data_q <= ram_rdata;
		end
		if (state_q == fbpa_pkg::ST_DIV_WAIT && div_res.done) begin
			free_idx_q <= free_idx_now;
		end
		if (state_q == fbpa_pkg::ST_AWR) begin
			mul_q <= MW'({found_row_q, found_bit_q}) * MW'(size_q);
		end
		end_prod_q <= PW'(n_act) * PW'(size_q);
		if (rsp_load) begin
			rsp_addr_q <= res_addr;
			rsp_idx_q  <= res_idx_ext[OIW-1:0];
			rsp_stat_q <= res_stat;
			rsp_free_q <= res_free_ext[BW-1:0];
			rsp_pool_q <= res_pool;
		end
	end

	assign req.ready         = req_rdy;
	assign rsp.valid         = rsp_vld_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.block_index   = rsp_idx_q;
	assign rsp.status        = rsp_stat_q;
	assign rsp.free_count    = rsp_free_q;
	assign rsp.in_pool       = rsp_pool_q;

	// The free count can never exceed the number of active blocks.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbpa_pkg::ST_RESP) |-> (KW'(cnt_q) <= KW'(n_act)))
		else $error("free count above active block count");

	// The block picked for allocation lies below the active count.
	a_alloc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbpa_pkg::ST_AWR) |-> (KW'({found_row_q, found_bit_q}) < KW'(n_act)))
		else $error("allocated block outside the active range");

	// The divider only finishes while the controller waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == fbpa_pkg::ST_DIV_WAIT))
		else $error("divider result arrived unexpectedly");

	// A loaded result is presented on the next cycle.
	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp_vld_q)
		else $error("loaded result not presented");

endmodule

@@ tb/sv/fixed_block_pool_allocator_tb.sv @@
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
	import fbpa_pkg::*;

	localparam int POOL_BLOCKS = DEF_NUM_BLOCKS;
	localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_ITEMS = 118;

	typedef struct packed {
		logic [ADDR_W-1:0]    block_address;
		logic [IDX_OUT_W-1:0] block_index;
		logic [STAT_W-1:0]    status;
		logic [BCNT_W-1:0]    free_count;
		logic                 in_pool;
	} reply_t;

	class alloc_tracker;
		logic [POOL_BLOCKS-1:0] used_marks;
		logic [ADDR_W-1:0]      base;
		logic [SIZE_W-1:0]      bsize;
		logic [BCNT_W-1:0]      bcount;
		reply_t                 predicted[$];
		int                     mismatches;
		int                     replies_seen;
		int                     req_counts[4];
		int                     full_seen;
		int                     not_found_seen;

		function new();
			used_marks = '0;
			base = '0;
			bsize = SIZE_RST;
			bcount = BCNT_RST;
			mismatches = 0;
			replies_seen = 0;
			full_seen = 0;
			not_found_seen = 0;
			foreach (req_counts[k]) begin
				req_counts[k] = 0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
			case (idx)
			CFG_BASE: begin
				base = data;
			end
			CFG_SIZE: begin
				bsize = data[SIZE_W-1:0];
			end
			CFG_COUNT: begin
				bcount = data[BCNT_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		function int active_blocks();
			return (bcount > POOL_BLOCKS) ? POOL_BLOCKS : int'(bcount);
		endfunction

		// Works out the reply to one accepted request word and updates the used marks.
		function void note_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
			reply_t      r;
			logic [63:0] start;
			logic [63:0] pool_end;
			int          n;
			int          free_blocks;
			bit          hit;
			n = active_blocks();
			r = '0;
			hit = 1'b0;
			free_blocks = 0;
			req_counts[kind]++;
			case (kind)
			REQ_ALLOC: begin
				r.status = STAT_FULL;
				for (int i = 0; i < n; i++) begin
					if (!hit && !used_marks[i]) begin
						hit = 1'b1;
						used_marks[i] = 1'b1;
						start = 64'(base) + 64'(i) * 64'(bsize);
						r.block_address = start[ADDR_W-1:0];
						r.block_index = IDX_OUT_W'(i);
						r.status = STAT_OK;
					end
				end
			end
			REQ_FREE: begin
				r.status = STAT_NOT_FOUND;
				for (int i = 0; i < n; i++) begin
					start = 64'(base) + 64'(i) * 64'(bsize);
					if (!hit && start == 64'(addr)) begin
						hit = 1'b1;
						used_marks[i] = 1'b0;
						r.block_index = IDX_OUT_W'(i);
						r.status = STAT_OK;
					end
				end
			end
			REQ_CLEAR: begin
				used_marks = '0;
			end
			default: begin
			end
			endcase
			// Marks above the active count are kept but never counted.
			for (int i = 0; i < n; i++) begin
				if (!used_marks[i]) begin
					free_blocks++;
				end
			end
			r.free_count = BCNT_W'(free_blocks);
			pool_end = 64'(base) + 64'(n) * 64'(bsize);
			r.in_pool = (64'(addr) >= 64'(base)) && (64'(addr) < pool_end);
			predicted.push_back(r);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 50) begin
				$display("[%0t] MISMATCH: %s", $time, msg);
			end
			mismatches++;
		endtask

		task check_reply(reply_t got);
			reply_t want;
			if (predicted.size() == 0) begin
				report_mismatch($sformatf("reply word %h arrived with nothing outstanding", got));
				return;
			end
			want = predicted.pop_front();
			replies_seen++;
			if (want.status == STAT_FULL) begin
				full_seen++;
			end
			if (want.status == STAT_NOT_FOUND) begin
				not_found_seen++;
			end
			if (got.block_address !== want.block_address) begin
				report_mismatch($sformatf("reply %0d block_address %h, expected %h",
					replies_seen, got.block_address, want.block_address));
			end
			if (got.block_index !== want.block_index) begin
				report_mismatch($sformatf("reply %0d block_index %0d, expected %0d",
					replies_seen, got.block_index, want.block_index));
			end
			if (got.status !== want.status) begin
				report_mismatch($sformatf("reply %0d status %0d, expected %0d",
					replies_seen, got.status, want.status));
			end
			if (got.free_count !== want.free_count) begin
				report_mismatch($sformatf("reply %0d free_count %0d, expected %0d",
					replies_seen, got.free_count, want.free_count));
			end
			if (got.in_pool !== want.in_pool) begin
				report_mismatch($sformatf("reply %0d in_pool %b, expected %b",
					replies_seen, got.in_pool, want.in_pool));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_wdata;

	fbpa_req_if req_ch();
	fbpa_rsp_if rsp_ch();

	alloc_tracker tracker = new();

	bit src_idle_on;
	bit sink_idle_on;
	bit long_hold_pending;
	int settings_written;

	logic [ADDR_W-1:0] cur_base;
	logic [SIZE_W-1:0] cur_size;
	int                cur_active;

	fixed_block_pool_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin : watch_ports
		reply_t got;
		if (req_ch.valid && req_ch.ready) begin
			tracker.note_request(req_ch.req_type, req_ch.address);
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.block_address = rsp_ch.block_address;
			got.block_index = rsp_ch.block_index;
			got.status = rsp_ch.status;
			got.free_count = rsp_ch.free_count;
			got.in_pool = rsp_ch.in_pool;
			tracker.check_reply(got);
		end
	end

	// Reply side: short random stalls, or one long hold-off when asked for.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("timed out with %0d replies outstanding", tracker.predicted.size());
		$display("fixed_block_pool_allocator test failed");
		$finish;
	end

	task automatic send_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.address <= addr;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Every request gives a reply, so once the last one is in the block is idle again.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.predicted.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, data);
		settings_written++;
	endtask

	task automatic configure(logic [ADDR_W-1:0] b, logic [SIZE_W-1:0] s, logic [BCNT_W-1:0] c);
		write_reg(CFG_BASE, b);
		write_reg(CFG_SIZE, ADDR_W'(s));
		write_reg(CFG_COUNT, ADDR_W'(c));
		cur_base = b;
		cur_size = s;
		cur_active = (c > POOL_BLOCKS) ? POOL_BLOCKS : int'(c);
	endtask

	function automatic logic [ADDR_W-1:0] block_start(int k);
		return cur_base + ADDR_W'(k) * ADDR_W'(cur_size);
	endfunction

	function automatic logic [ADDR_W-1:0] pick_address();
		case ($urandom_range(0, 5))
		0, 1: begin
			return $urandom;
		end
		2: begin
			return block_start($urandom_range(0, cur_active));
		end
		3: begin
			return cur_base - 1;
		end
		4: begin
			return block_start(cur_active) - 1;
		end
		default: begin
			return block_start($urandom_range(0, cur_active)) + $urandom_range(1, 3);
		end
		endcase
	endfunction

	task automatic pick_setting(int p);
		logic [ADDR_W-1:0] b;
		logic [SIZE_W-1:0] s;
		logic [BCNT_W-1:0] c;
		b = $urandom;
		s = SIZE_W'($urandom_range(1, 65535));
		c = BCNT_W'($urandom_range(1, 12));
		case (p % 7)
		1: begin
			b = '0;
			s = 16'd1;
			c = 7'd64;
		end
		2: begin
			b = 32'hFFFF_FFFF;
			s = 16'hFFFF;
			c = 7'd127;
		end
		3: begin
			s = '0;
		end
		4: begin
			c = '0;
		end
		5: begin
			c = BCNT_W'($urandom_range(0, 127));
		end
		6: begin
			b = ADDR_W'($urandom_range(0, 255));
			s = SIZE_W'($urandom_range(1, 16));
			c = BCNT_W'($urandom_range(20, 64));
		end
		default: begin
		end
		endcase
		configure(b, s, c);
	endtask

	// Mostly allocate and free of real block starts, with clears, no-ops and stray addresses.
	task automatic random_item();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			send_request(REQ_ALLOC, pick_address());
		end else if (roll < 80) begin
			send_request(REQ_FREE, block_start($urandom_range(0, cur_active + 1)));
		end else if (roll < 90) begin
			send_request(REQ_FREE, pick_address());
		end else if (roll < 95) begin
			send_request(REQ_CLEAR, pick_address());
		end else begin
			send_request(REQ_NOP, pick_address());
		end
	endtask

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_ALLOC;
		req_ch.address <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BASE;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		long_hold_pending = 1'b0;
		settings_written = 0;
		cur_base = '0;
		cur_size = SIZE_RST;
		cur_active = POOL_BLOCKS;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Settings as left by reset.
		send_request(REQ_ALLOC, 32'h0000_0000);
		send_request(REQ_ALLOC, 32'hFFFF_FFFF);
		send_request(REQ_FREE, 32'h0000_0000);
		send_request(REQ_FREE, 32'h0000_0000);
		send_request(REQ_FREE, 32'hFFFF_FFFF);
		send_request(REQ_NOP, 32'd63);
		send_request(REQ_CLEAR, 32'd64);
		send_request(REQ_ALLOC, 32'h5555_AAAA);
		settle();

		// The second block starts beyond the 32-bit address space.
		configure(32'hFFFF_FFF0, 16'hFFFF, 7'd3);
		send_request(REQ_ALLOC, 32'hFFFF_FFF0);
		send_request(REQ_ALLOC, 32'h0000_FFEF);
		send_request(REQ_FREE, 32'h0000_FFEF);
		send_request(REQ_FREE, 32'hFFFF_FFF0);
		send_request(REQ_NOP, 32'hFFFF_FFFF);
		settle();

		// With a zero block size every block shares the base address.
		configure(32'h0000_1234, 16'd0, 7'd5);
		send_request(REQ_ALLOC, 32'h0000_1234);
		send_request(REQ_ALLOC, 32'h0000_1234);
		send_request(REQ_FREE, 32'h0000_1234);
		send_request(REQ_ALLOC, 32'h0000_1233);
		settle();

		configure(32'h0000_1000, 16'd16, 7'd0);
		send_request(REQ_ALLOC, 32'h0000_1000);
		send_request(REQ_FREE, 32'h0000_1000);
		settle();

		// A count above the built capacity, then marks left above a shrunk count.
		configure(32'h0000_0000, 16'd1, 7'd127);
		send_request(REQ_ALLOC, 32'd64);
		send_request(REQ_ALLOC, 32'd63);
		send_request(REQ_ALLOC, 32'd0);
		settle();
		configure(32'h0000_0000, 16'd1, 7'd1);
		send_request(REQ_ALLOC, 32'd1);
		send_request(REQ_CLEAR, 32'd0);
		settle();
		configure(32'h0000_0000, 16'd1, 7'd127);
		send_request(REQ_ALLOC, 32'd2);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p >= RANDOM_PHASES - 2) begin
				src_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end
			pick_setting(p);
			if (p == 1) begin
				long_hold_pending = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				random_item();
			end
			settle();
		end

		if (tracker.predicted.size() != 0) begin
			tracker.report_mismatch($sformatf("%0d replies never arrived",
				tracker.predicted.size()));
		end
		$display("Covered %0d allocate, %0d free, %0d clear and %0d no-op words over %0d register writes.",
			tracker.req_counts[REQ_ALLOC], tracker.req_counts[REQ_FREE],
			tracker.req_counts[REQ_CLEAR], tracker.req_counts[REQ_NOP], settings_written);
		$display("Checked %0d replies, %0d of them pool full and %0d address not found; %0d mismatches.",
			tracker.replies_seen, tracker.full_seen, tracker.not_found_seen, tracker.mismatches);
		if (tracker.mismatches == 0) begin
			$display("fixed_block_pool_allocator test passed");
		end else begin
			$display("fixed_block_pool_allocator test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/fbpa_pkg.sv
sv/fbpa_req_if.sv
sv/fbpa_rsp_if.sv
sv/fbpa_ram.sv
sv/fbpa_div.sv
sv/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_tb.sv
